// ===== rtl/b57_pkg.sv =====
// Shared types and constants of the base57 block decoder.
// Holds the command format passed from the front part to the back part.
// No dependencies.
package b57_pkg;

	// Number base and the digit used to pad a partial block.
	localparam int unsigned BASE = 57;
	localparam logic [5:0] PAD_DIGIT = 6'd56;

	// Width of the reported error position.
	localparam int unsigned POS_OUT_W = 32;

	// Result item kinds.
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_OK   = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// Commands from the front part to the back part.
	typedef enum logic [1:0] {
		OP_ERROR     = 2'd0,
		OP_BLOCK     = 2'd1,
		OP_BLOCK_END = 2'd2,
		OP_FINISH    = 2'd3
	} cmd_op_t;

	// One queued command: a full block, a flush request or an error.
	typedef struct packed {
		cmd_op_t               op;
		logic [63:0]           value;
		logic [3:0]            count;
		logic [POS_OUT_W-1:0]  pos;
	} cmd_t;

	// Multiply by 57 and add a digit, modulo 2^64 (57 = 64 - 8 + 1).
	function automatic logic [63:0] mul57_add(input logic [63:0] a, input logic [5:0] d);
		return (a << 6) - (a << 3) + a + {58'd0, d};
	endfunction

endpackage

// ===== rtl/b57_cmd_fifo.sv =====
// Small command queue between the front and back parts of the decoder.
// Register storage, one write and one read port. No dependencies.
module b57_cmd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/b57_front.sv =====
// Front part of the base57 decoder: takes one character per cycle unless the
// queue is full, classifies it, accumulates digits, queues commands. Uses b57_pkg.
module b57_front #(
	parameter int POSITION_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic           cfg_data,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [7:0]     s_axis_tdata,
	input  logic           s_axis_tlast,
	input  logic           queue_full,
	output logic           push,
	output b57_pkg::cmd_t  push_cmd
);

	import b57_pkg::*;

	localparam logic [63:0] LIMIT_BEFORE_LAST = 64'h047dc11f7047dc11;
	localparam int EXT_W = (POSITION_WIDTH > POS_OUT_W) ? POSITION_WIDTH : POS_OUT_W;

	localparam logic CFG_SKIP_SPACE = 1'b0;
	localparam logic CFG_NUL_ENDS   = 1'b1;

	typedef enum logic [1:0] {
		CH_DIGIT = 2'd0,
		CH_SPACE = 2'd1,
		CH_NUL   = 2'd2,
		CH_BAD   = 2'd3
	} char_class_t;

	typedef struct packed {
		char_class_t cls;
		logic [5:0]  digit;
	} char_info_t;

	// Map a character to its class and, for alphabet members, its digit value.
	function automatic char_info_t classify(input logic [7:0] c);
		char_info_t r;
		r.cls   = CH_DIGIT;
		r.digit = '0;
		if (c == 8'd0) begin
			r.cls = CH_NUL;
		end else if (c inside {[8'd9:8'd13], 8'd32}) begin
			r.cls = CH_SPACE;
		end else if (c inside {[8'h41:8'h48]}) begin
			r.digit = 6'(c - 8'h41);
		end else if (c inside {[8'h4a:8'h4e]}) begin
			r.digit = 6'(c - 8'h4a + 8'd8);
		end else if (c inside {[8'h50:8'h5a]}) begin
			r.digit = 6'(c - 8'h50 + 8'd13);
		end else if (c inside {[8'h61:8'h6b]}) begin
			r.digit = 6'(c - 8'h61 + 8'd24);
		end else if (c inside {[8'h6d:8'h7a]}) begin
			r.digit = 6'(c - 8'h6d + 8'd35);
		end else if (c inside {[8'h32:8'h39]}) begin
			r.digit = 6'(c - 8'h32 + 8'd49);
		end else begin
			r.cls = CH_BAD;
		end
		return r;
	endfunction

	// Low bits of a character position, zero-extended when the counter is narrower.
	function automatic logic [POS_OUT_W-1:0] to_out_pos(input logic [POSITION_WIDTH-1:0] p);
		logic [EXT_W-1:0] e;
		e = EXT_W'(p);
		return e[POS_OUT_W-1:0];
	endfunction

	logic                      skip_space_q;
	logic                      nul_ends_q;
	logic [63:0]               acc_q;
	logic [3:0]                cnt_q;
	logic [POSITION_WIDTH-1:0] pos_q;
	logic [POSITION_WIDTH-1:0] hpos_q;
	logic                      drop_q;

	logic                      accept;
	logic [POSITION_WIDTH-1:0] pos_next;
	char_info_t                info;
	logic [63:0]               prod;
	logic [63:0]               acc_digit;
	logic [64:0]               sum_ext;
	logic [63:0]               nxt_acc;
	logic [3:0]                nxt_cnt;
	logic [POSITION_WIDTH-1:0] nxt_hpos;
	logic                      nxt_drop;

	assign s_axis_tready = !queue_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign pos_next      = pos_q + 1'b1;
	assign info          = classify(s_axis_tdata);
	assign prod          = mul57_add(acc_q, 6'd0);
	assign acc_digit     = prod + {58'd0, info.digit};
	assign sum_ext       = {1'b0, prod} + {59'd0, info.digit};

	// Decide what this character does and which command, if any, it queues.
	always_comb begin
		nxt_acc  = acc_q;
		nxt_cnt  = cnt_q;
		nxt_hpos = hpos_q;
		nxt_drop = drop_q;
		push     = 1'b0;
		push_cmd = '0;
		if (accept && !drop_q) begin
			case (info.cls)
				CH_SPACE: begin
					if (!skip_space_q) begin
						push         = 1'b1;
						push_cmd.op  = OP_ERROR;
						push_cmd.pos = to_out_pos(pos_next);
						nxt_drop     = 1'b1;
					end else if (s_axis_tlast) begin
						push           = 1'b1;
						push_cmd.op    = OP_FINISH;
						push_cmd.value = acc_q;
						push_cmd.count = cnt_q;
						push_cmd.pos   = to_out_pos(hpos_q);
					end
				end
				CH_NUL: begin
					push     = 1'b1;
					nxt_drop = 1'b1;
					if (nul_ends_q) begin
						push_cmd.op    = OP_FINISH;
						push_cmd.value = acc_q;
						push_cmd.count = cnt_q;
						push_cmd.pos   = to_out_pos(hpos_q);
					end else begin
						push_cmd.op  = OP_ERROR;
						push_cmd.pos = to_out_pos(pos_next);
					end
				end
				CH_DIGIT: begin
					if (cnt_q < 4'd10) begin
						// One of the first ten digits of a block.
						nxt_hpos = pos_next;
						nxt_acc  = acc_digit;
						nxt_cnt  = cnt_q + 4'd1;
						if (s_axis_tlast) begin
							push           = 1'b1;
							push_cmd.op    = OP_FINISH;
							push_cmd.value = acc_digit;
							push_cmd.count = cnt_q + 4'd1;
							push_cmd.pos   = to_out_pos(pos_next);
						end
					end else if (acc_q > LIMIT_BEFORE_LAST) begin
						push         = 1'b1;
						push_cmd.op  = OP_ERROR;
						push_cmd.pos = to_out_pos(hpos_q);
						nxt_drop     = 1'b1;
					end else if (sum_ext[64]) begin
						push         = 1'b1;
						push_cmd.op  = OP_ERROR;
						push_cmd.pos = to_out_pos(pos_next);
						nxt_drop     = 1'b1;
					end else begin
						// Eleventh digit completes a full block of eight bytes.
						push           = 1'b1;
						push_cmd.op    = s_axis_tlast ? OP_BLOCK_END : OP_BLOCK;
						push_cmd.value = sum_ext[63:0];
						nxt_acc        = '0;
						nxt_cnt        = '0;
					end
				end
				default: begin
					push         = 1'b1;
					push_cmd.op  = OP_ERROR;
					push_cmd.pos = to_out_pos(pos_next);
					nxt_drop     = 1'b1;
				end
			endcase
		end
	end

	// Configuration registers and message state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_space_q <= 1'b1;
			nul_ends_q   <= 1'b0;
			acc_q        <= '0;
			cnt_q        <= '0;
			pos_q        <= '0;
			hpos_q       <= '0;
			drop_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SKIP_SPACE: skip_space_q <= cfg_data;
					CFG_NUL_ENDS:   nul_ends_q   <= cfg_data;
					default:        ;
				endcase
			end
			if (accept) begin
				if (s_axis_tlast) begin
					acc_q  <= '0;
					cnt_q  <= '0;
					pos_q  <= '0;
					hpos_q <= '0;
					drop_q <= 1'b0;
				end else begin
					acc_q  <= nxt_acc;
					cnt_q  <= nxt_cnt;
					pos_q  <= pos_next;
					hpos_q <= nxt_hpos;
					drop_q <= nxt_drop;
				end
			end
		end
	end

endmodule

// ===== rtl/b57_back.sv =====
// Back part of the base57 decoder: carries out queued commands, emits bytes,
// flushes and checks a partial block. Uses b57_pkg.
module b57_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      queue_empty,
	input  b57_pkg::cmd_t             pop_cmd,
	output logic                      pop,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [39:0]               m_axis_tdata,
	output logic [1:0]                m_axis_tuser,
	output logic                      m_axis_tlast
);

	import b57_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_CHECK = 6'b000100,
		ST_TAIL  = 6'b001000,
		ST_BYTES = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	// Bytes carried by a partial block of the given digit count; zero if illegal.
	function automatic logic [2:0] len_bytes(input logic [3:0] count);
		logic [2:0] r;
		case (count)
			4'd2:    r = 3'd1;
			4'd3:    r = 3'd2;
			4'd5:    r = 3'd3;
			4'd6:    r = 3'd4;
			4'd7:    r = 3'd5;
			4'd9:    r = 3'd6;
			4'd10:   r = 3'd7;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// Largest legal padded ten-digit value for a partial block of this byte length.
	function automatic logic [63:0] part_max(input logic [2:0] dlen);
		logic [63:0] r;
		case (dlen)
			3'd1:    r = 64'h047944da05d3ad0c;
			3'd2:    r = 64'h047dbddd16ed96b0;
			3'd3:    r = 64'h047dc11aff23a734;
			3'd4:    r = 64'h047dc11f6c4df39d;
			3'd5:    r = 64'h047dc11f70446bdc;
			3'd6:    r = 64'h047dc11f7047d7ca;
			3'd7:    r = 64'h047dc11f7047dc0d;
			default: r = 64'd0;
		endcase
		return r;
	endfunction

	// Largest part below the kept bytes that still leaves the last real digit
	// intact: 57^k - 1 for the k pad digits of a block of this byte length.
	function automatic logic [63:0] tail_max(input logic [2:0] dlen);
		logic [63:0] r;
		case (dlen)
			3'd1:    r = 64'd6351461955384056;
			3'd2:    r = 64'd111429157112000;
			3'd3:    r = 64'd34296447248;
			3'd4:    r = 64'd601692056;
			3'd5:    r = 64'd10556000;
			3'd6:    r = 64'd3248;
			3'd7:    r = 64'd56;
			default: r = 64'd0;
		endcase
		return r;
	endfunction

	state_t               state_q;
	logic [63:0]          acc_q;
	logic [POS_OUT_W-1:0] pos_q;
	logic [2:0]           dlen_q;
	logic [3:0]           pad_q;
	logic [3:0]           nbytes_q;
	logic                 succ_q;
	logic [1:0]           emit_kind_q;

	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic [1:0]           out_kind_q;
	logic [POS_OUT_W-1:0] out_pos_q;
	logic                 out_last_q;

	logic [63:0]          pad_acc;
	logic [2:0]           cmd_dlen;
	logic [63:0]          tail_bits;
	logic                 item_valid;
	logic [7:0]           item_byte;
	logic [1:0]           item_kind;
	logic [POS_OUT_W-1:0] item_pos;
	logic                 item_last;
	logic                 out_load;

	assign pop       = (state_q == ST_IDLE) && !queue_empty;
	assign pad_acc   = mul57_add(acc_q, PAD_DIGIT);
	assign cmd_dlen  = len_bytes(pop_cmd.count);
	assign tail_bits = acc_q & (64'hffff_ffff_ffff_ffff >> {dlen_q, 3'b000});

	// Result item offered to the output register.
	always_comb begin
		item_valid = (state_q == ST_BYTES) || (state_q == ST_EMIT);
		item_byte  = (state_q == ST_BYTES) ? acc_q[63:56] : 8'd0;
		item_kind  = (state_q == ST_BYTES) ? KIND_DATA : emit_kind_q;
		item_pos   = ((state_q == ST_EMIT) && (emit_kind_q == KIND_ERR)) ? pos_q : '0;
		item_last  = (state_q == ST_EMIT) || ((nbytes_q == 4'd1) && !succ_q);
	end

	assign out_load = item_valid && (!out_valid_q || m_axis_tready);

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			pos_q       <= '0;
			dlen_q      <= '0;
			pad_q       <= '0;
			nbytes_q    <= '0;
			succ_q      <= 1'b0;
			emit_kind_q <= KIND_OK;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (pop_cmd.op)
							OP_ERROR: begin
								emit_kind_q <= KIND_ERR;
								pos_q       <= pop_cmd.pos;
								state_q     <= ST_EMIT;
							end
							OP_BLOCK, OP_BLOCK_END: begin
								acc_q    <= pop_cmd.value;
								nbytes_q <= 4'd8;
								succ_q   <= (pop_cmd.op == OP_BLOCK_END);
								state_q  <= ST_BYTES;
							end
							OP_FINISH: begin
								pos_q <= pop_cmd.pos;
								if (pop_cmd.count == 4'd0) begin
									emit_kind_q <= KIND_OK;
									state_q     <= ST_EMIT;
								end else if (cmd_dlen == 3'd0) begin
									emit_kind_q <= KIND_ERR;
									state_q     <= ST_EMIT;
								end else begin
									acc_q   <= pop_cmd.value;
									dlen_q  <= cmd_dlen;
									pad_q   <= 4'd10 - pop_cmd.count;
									state_q <= ST_PAD;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				// Pad the partial block to ten digits with the top digit.
				ST_PAD: begin
					if (pad_q == 4'd0) begin
						state_q <= ST_CHECK;
					end else begin
						acc_q <= pad_acc;
						pad_q <= pad_q - 4'd1;
					end
				end
				// Range check, then append the eleventh pad digit.
				ST_CHECK: begin
					if (acc_q > part_max(dlen_q)) begin
						emit_kind_q <= KIND_ERR;
						state_q     <= ST_EMIT;
					end else begin
						acc_q   <= pad_acc;
						state_q <= ST_TAIL;
					end
				end
				// Dropping the bits below the kept bytes must not change the last
				// real digit; it holds exactly when those bits stay below 57^k.
				ST_TAIL: begin
					if (tail_bits > tail_max(dlen_q)) begin
						emit_kind_q <= KIND_ERR;
						state_q     <= ST_EMIT;
					end else begin
						nbytes_q <= {1'b0, dlen_q};
						succ_q   <= 1'b1;
						state_q  <= ST_BYTES;
					end
				end
				// Emit bytes from the top of the value, most significant first.
				ST_BYTES: begin
					if (out_load) begin
						acc_q    <= {acc_q[55:0], 8'd0};
						nbytes_q <= nbytes_q - 4'd1;
						if (nbytes_q == 4'd1) begin
							if (succ_q) begin
								emit_kind_q <= KIND_OK;
								state_q     <= ST_EMIT;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_kind_q  <= KIND_DATA;
			out_pos_q   <= '0;
			out_last_q  <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_byte_q  <= item_byte;
			out_kind_q  <= item_kind;
			out_pos_q   <= item_pos;
			out_last_q  <= item_last;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_pos_q, out_byte_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/base57_block_decoder.sv =====
// Top level of the base57 block decoder.
// Instantiates b57_front, b57_cmd_fifo and b57_back; uses b57_pkg.
//
// Decodes base57 text (one character per input item, tlast on the final
// character) into byte items. The front part takes one character per cycle
// as long as the command queue has room: each digit is folded into a 64-bit
// accumulator by one multiply-by-57-add. Each full block of eleven digits
// becomes eight data items, sent one per cycle by the back part while the
// output accepts them, so steady text flows at one character per cycle. At
// the end of a message a partial block of n digits is flushed by the back
// part (padding one digit per cycle, range check, check of the final digit)
// before its bytes and the success item leave; during that time the front
// keeps accepting until the queue fills. An error yields one error item
// carrying the 1-based character position, and the rest of the message is
// dropped. Output tuser is the item kind: data, success or error.
// Configuration: register 0 skip_space, register 1 nul_ends.
module base57_block_decoder #(
	parameter int POSITION_WIDTH = 32,
	parameter int QUEUE_DEPTH    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	// Input characters.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic        s_axis_tlast,   // final_char
	// Result items.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] error_pos
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast    // end_of_run
);

	import b57_pkg::*;

	cmd_t push_cmd;
	cmd_t pop_cmd;
	logic push;
	logic pop;
	logic queue_full;
	logic queue_empty;

	// Character intake and digit accumulation.
	b57_front #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.queue_full    (queue_full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	// Command queue between the two parts.
	b57_cmd_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (pop_cmd),
		.empty     (queue_empty)
	);

	// Byte emission and partial block flush.
	b57_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.queue_empty   (queue_empty),
		.pop_cmd       (pop_cmd),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== tb/sv/b57_tb_pkg.sv =====
`timescale 1ns / 100ps
// Constants that the base57 decoder testbench and its checker both use.
// Register indexes, the digit alphabet and the special character codes.
// No dependencies.
package b57_tb_pkg;

	// Configuration register indexes.
	localparam logic REG_SKIP_SPACE = 1'b0;
	localparam logic REG_NUL_ENDS   = 1'b1;

	// Digit alphabet, digit 0 in the leftmost character.
	localparam logic [8*57-1:0] DIGIT_CHARS =
		"ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz23456789";

	// Character codes with a meaning of their own.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Largest block value before the eleventh digit whose product by 57 cannot overflow.
	localparam logic [63:0] LAST_DIGIT_CEILING = 64'h047dc11f7047dc11;

	// Character that stands for a digit value.
	function automatic logic [7:0] digit_char(input logic [5:0] d);
		return DIGIT_CHARS[8 * (56 - int'(d)) +: 8];
	endfunction

endpackage

// ===== tb/sv/base57_block_decoder_checker.sv =====
`timescale 1ns / 100ps
// Checker of the base57 block decoder: follows register writes and accepted
// characters, predicts the result items and compares each one as it leaves.
// Depends on b57_pkg (item kinds) and b57_tb_pkg (registers, alphabet).
module base57_block_decoder_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic        s_axis_tlast,   // final_char
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] error_pos
	input  logic [1:0]  m_axis_tuser,   // [1:0] kind
	input  logic        m_axis_tlast,   // end_of_run
	output int          errors,
	output int          pending
);
	import b57_pkg::*;
	import b57_tb_pkg::*;

	// Character classes beyond the digit values.
	localparam int CLS_SPACE = 60;
	localparam int CLS_NUL   = 61;
	localparam int CLS_BAD   = 62;

	typedef struct packed {
		logic [7:0]  data;
		logic [1:0]  kind;
		logic [31:0] epos;
		logic        tail;
	} decoded_item_t;

	// Copy of the decoder state and registers.
	logic        skip_sp;
	logic        nul_end;
	logic [63:0] acc;
	logic [3:0]  ndig;
	logic [31:0] pos;
	logic [31:0] held_pos;
	logic [5:0]  held_dig;
	logic        dropping;

	decoded_item_t decoded_q[$];
	decoded_item_t char_items[$];
	int err_n = 0;

	function automatic int classify_char(input logic [7:0] c);
		int i;
		if (c == CH_NUL)
			return CLS_NUL;
		if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)
			return CLS_SPACE;
		for (i = 0; i < 57; i++)
			if (digit_char(6'(i)) == c)
				return i;
		return CLS_BAD;
	endfunction

	function automatic void add_item(input logic [7:0] b, input logic [1:0] k,
			input logic [31:0] p);
		decoded_item_t it;
		it.data = b;
		it.kind = k;
		it.epos = p;
		it.tail = 1'b0;
		char_items.push_back(it);
	endfunction

	// Bytes carried by a partial block of n digits; -1 for illegal lengths.
	function automatic int bytes_for_digits(input logic [3:0] n);
		case (n)
			4'd2: return 1;
			4'd3: return 2;
			4'd5: return 3;
			4'd6: return 4;
			4'd7: return 5;
			4'd9: return 6;
			4'd10: return 7;
			default: return -1;
		endcase
	endfunction

	// Largest padded ten-digit value allowed for a partial block of n bytes.
	function automatic logic [63:0] partial_ceiling(input int nbytes);
		case (nbytes)
			1: return 64'h047944da05d3ad0c;
			2: return 64'h047dbddd16ed96b0;
			3: return 64'h047dc11aff23a734;
			4: return 64'h047dc11f6c4df39d;
			5: return 64'h047dc11f70446bdc;
			6: return 64'h047dc11f7047d7ca;
			default: return 64'h047dc11f7047dc0d;
		endcase
	endfunction

	function automatic void clear_message();
		acc = 64'd0;
		ndig = 4'd0;
		pos = 32'd0;
		held_pos = 32'd0;
		held_dig = 6'd0;
		dropping = 1'b0;
	endfunction

	// Message end: pad and check any partial block, emit its bytes and success, or an error.
	function automatic void flush_partial();
		int nbytes;
		int i;
		logic [63:0] v;
		logic [63:0] t;
		if (ndig != 4'd0) begin
			nbytes = bytes_for_digits(ndig);
			if (nbytes < 0) begin
				add_item(8'd0, KIND_ERR, held_pos);
				return;
			end
			v = acc;
			for (i = int'(ndig); i < 10; i++)
				v = v * 64'd57 + 64'd56;
			if (v > partial_ceiling(nbytes)) begin
				add_item(8'd0, KIND_ERR, held_pos);
				return;
			end
			v = v * 64'd57 + 64'd56;
			// The last digit must be the one that the truncated value gives back.
			t = (v >> (8 * (8 - nbytes))) << (8 * (8 - nbytes));
			for (i = 11 - int'(ndig); i > 0; i--)
				t = t / 64'd57;
			if ((t % 64'd57) != 64'(held_dig)) begin
				add_item(8'd0, KIND_ERR, held_pos);
				return;
			end
			for (i = 0; i < nbytes; i++)
				add_item(8'(v >> (8 * (7 - i))), KIND_DATA, 32'd0);
		end
		add_item(8'd0, KIND_OK, 32'd0);
	endfunction

	// Work out the result items of one accepted character.
	function automatic void decode_char(input logic [7:0] c, input logic last);
		int cls;
		int i;
		logic [63:0] prod;
		decoded_item_t it;
		char_items.delete();
		pos = pos + 32'd1;
		if (!dropping) begin
			cls = classify_char(c);
			if (cls == CLS_SPACE) begin
				if (!skip_sp) begin
					add_item(8'd0, KIND_ERR, pos);
					dropping = 1'b1;
				end else if (last) begin
					flush_partial();
				end
			end else if (cls == CLS_NUL && nul_end) begin
				flush_partial();
				dropping = 1'b1;
			end else if (cls >= 57) begin
				add_item(8'd0, KIND_ERR, pos);
				dropping = 1'b1;
			end else if (ndig < 4'd10) begin
				held_pos = pos;
				held_dig = 6'(cls);
				acc = acc * 64'd57 + 64'(cls);
				ndig = ndig + 4'd1;
				if (last)
					flush_partial();
			end else if (acc > LAST_DIGIT_CEILING) begin
				add_item(8'd0, KIND_ERR, held_pos);
				dropping = 1'b1;
			end else begin
				// Eleventh digit: the block is complete unless the sum overflows.
				prod = acc * 64'd57;
				if (prod > ~64'd0 - 64'(cls)) begin
					add_item(8'd0, KIND_ERR, pos);
					dropping = 1'b1;
				end else begin
					prod = prod + 64'(cls);
					for (i = 0; i < 8; i++)
						add_item(8'(prod >> (8 * (7 - i))), KIND_DATA, 32'd0);
					acc = 64'd0;
					ndig = 4'd0;
					if (last)
						flush_partial();
				end
			end
		end
		if (char_items.size() > 0) begin
			it = char_items.pop_back();
			it.tail = 1'b1;
			char_items.push_back(it);
		end
		foreach (char_items[i])
			decoded_q.push_back(char_items[i]);
		if (last)
			clear_message();
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			err_n++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endfunction

	// Follow the channels at each edge: registers, characters, then results.
	always @(posedge clk or negedge arst_n) begin : watch
		decoded_item_t want;
		if (!arst_n) begin
			skip_sp = 1'b1;
			nul_end = 1'b0;
			clear_message();
			decoded_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_SKIP_SPACE)
					skip_sp = cfg_data;
				else
					nul_end = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready)
				decode_char(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (decoded_q.size() == 0) begin
					err_n++;
					$display("%0t: unexpected item, expected none, got byte 0x%0h kind %0d pos %0d last %0b",
						$time, m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[39:8],
						m_axis_tlast);
				end else begin
					want = decoded_q.pop_front();
					check_field("out_byte", 32'(want.data), 32'(m_axis_tdata[7:0]));
					check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
					check_field("error_pos", want.epos, m_axis_tdata[39:8]);
					check_field("end_of_run", 32'(want.tail), 32'(m_axis_tlast));
				end
			end
			errors <= err_n;
			pending <= decoded_q.size();
		end
	end

endmodule

// ===== tb/sv/base57_block_decoder_tb.sv =====
`timescale 1ns / 100ps
// Top of the base57 block decoder testbench: clock, reset, register writes,
// character messages and the result sink, with the verdict at the end.
// Depends on base57_block_decoder, base57_block_decoder_checker and b57_tb_pkg.
module base57_block_decoder_tb;
	import b57_tb_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 150;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASE_ITEMS     = 95;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic        cfg_data = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int errors;
	int pending;
	int cycles = 0;
	int sent = 0;
	bit calm = 1'b0;
	bit hold_off_req = 1'b0;
	bit hold_done = 1'b0;
	logic skip_on = 1'b1;
	logic nul_on = 1'b0;
	logic [7:0] text_q[$];

	base57_block_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	base57_block_decoder_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.errors(errors),
		.pending(pending)
	);

	always #6 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("base57_block_decoder_tb: errors");
			$finish;
		end
	end

	// Result sink: random stall bursts, one long hold-off on request, none when calm.
	initial begin : sink
		int span;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				span = $urandom_range(1, 11);
				m_axis_tready <= 1'b0;
				repeat (span) @(posedge clk);
			end else begin
				span = $urandom_range(1, 24);
				m_axis_tready <= 1'b1;
				repeat (span) @(posedge clk);
			end
		end
	end

	// Digit idx (0 the most significant) of the eleven-digit form of v.
	function automatic logic [5:0] digit_at(input logic [63:0] v, input int idx);
		logic [63:0] q;
		int k;
		q = v;
		for (k = idx; k < 10; k++)
			q = q / 64'd57;
		return 6'(q % 64'd57);
	endfunction

	// Digits that carry a partial block of n bytes.
	function automatic int digits_for_bytes(input int n);
		case (n)
			1: return 2;
			2: return 3;
			3: return 5;
			4: return 6;
			5: return 7;
			6: return 9;
			7: return 10;
			default: return 11;
		endcase
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_space();
		int k;
		k = $urandom_range(0, 5);
		if (k == 5)
			return CH_SPACE;
		return CH_TAB + 8'(k);
	endfunction

	// Characters that break a message: high codes, look-alikes, NUL, whitespace.
	function automatic logic [7:0] pick_noise();
		case ($urandom_range(0, 5))
			0: return 8'($urandom_range(0, 255));
			1: return 8'($urandom_range(128, 255));
			2: return CH_NUL;
			3: return pick_space();
			default: begin
				case ($urandom_range(0, 4))
					0: return "I";
					1: return "O";
					2: return "l";
					3: return "0";
					default: return "1";
				endcase
			end
		endcase
	endfunction

	// Leading digits of v, with whitespace now and then.
	task automatic push_block(input logic [63:0] v, input int ndigits);
		int i;
		for (i = 0; i < ndigits; i++) begin
			if ($urandom_range(0, skip_on ? 11 : 59) == 0)
				text_q.push_back(pick_space());
			text_q.push_back(digit_char(digit_at(v, i)));
		end
	endtask

	// Well-formed text for nbytes random bytes.
	task automatic add_valid_text(input int nbytes);
		logic [63:0] v;
		int i;
		int j;
		int k;
		i = 0;
		while (i < nbytes) begin
			k = (nbytes - i > 8) ? 8 : nbytes - i;
			v = 64'd0;
			for (j = 0; j < k; j++)
				v = {v[55:0], pick_byte()};
			v = v << (8 * (8 - k));
			push_block(v, digits_for_bytes(k));
			i += k;
		end
	endtask

	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent++;
	endtask

	// Send the collected text, the last character marked final.
	task automatic send_text();
		int i;
		for (i = 0; i < text_q.size(); i++)
			send_char(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	// Close a message: on whitespace, on NUL with trailing junk, or on its last digit.
	task automatic end_message();
		int i;
		if (text_q.size() == 0 || $urandom_range(0, 4) == 0) begin
			text_q.push_back(pick_space());
		end else if (nul_on && $urandom_range(0, 3) == 0) begin
			text_q.push_back(CH_NUL);
			for (i = $urandom_range(0, 3); i > 0; i--)
				text_q.push_back(8'($urandom_range(0, 255)));
		end
		send_text();
	endtask

	task automatic random_message();
		int kind;
		int i;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			if ($urandom_range(0, 3) == 0)
				add_valid_text($urandom_range(0, 24));
			else
				add_valid_text($urandom_range(0, 12));
		end else if (kind == 7) begin
			// Well-formed text with one character spoiled.
			add_valid_text($urandom_range(1, 16));
			text_q[$urandom_range(0, text_q.size() - 1)] = pick_noise();
		end else if (kind == 8) begin
			// Random digits: wrong lengths, range failures, last-digit mismatches.
			if ($urandom_range(0, 2) == 0)
				add_valid_text(8);
			for (i = $urandom_range(1, 10); i > 0; i--)
				text_q.push_back(digit_char(6'($urandom_range(0, 56))));
		end else begin
			// Blocks near the 64-bit limit.
			if ($urandom_range(0, 1) == 0) begin
				text_q.push_back(digit_char(6'($urandom_range(49, 56))));
				for (i = 1; i < 10; i++)
					text_q.push_back(digit_char(6'($urandom_range(0, 56))));
			end else begin
				for (i = 1; i <= 10; i++)
					text_q.push_back(digit_char(digit_at(LAST_DIGIT_CEILING, i)));
			end
			text_q.push_back(digit_char(6'($urandom_range(40, 56))));
			for (i = $urandom_range(0, 4); i > 0; i--)
				text_q.push_back(digit_char(6'($urandom_range(0, 56))));
		end
		end_message();
	endtask

	task automatic run_phase(input int budget, input bit with_hold);
		int start;
		start = sent;
		while (sent - start < budget) begin
			if (with_hold && !hold_done && sent - start >= budget / 3) begin
				hold_off_req = 1'b1;
				hold_done = 1'b1;
			end
			random_message();
		end
	endtask

	// Stop offering characters and wait until every expected item has left.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Change registers only once the decoder has gone quiet.
	task automatic reconfigure(input logic skip, input logic nul);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_SKIP_SPACE, skip);
		write_reg(REG_NUL_ENDS, nul);
		skip_on = skip;
		nul_on = nul;
	endtask

	initial begin : stimulus
		int i;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(REG_SKIP_SPACE, 1'b1);
		write_reg(REG_NUL_ENDS, 1'b0);

		// Eleventh digit overflows on the add: the first ten sit at the ceiling.
		for (i = 1; i <= 10; i++)
			text_q.push_back(digit_char(digit_at(LAST_DIGIT_CEILING, i)));
		text_q.push_back(digit_char(6'd56));
		send_text();
		// Value before the eleventh digit is already above the ceiling.
		repeat (10) text_q.push_back(digit_char(6'd56));
		text_q.push_back(digit_char(6'd0));
		send_text();
		// Highest code, NUL while it does not end messages, and an empty message.
		text_q.push_back(8'hFF);
		send_text();
		text_q.push_back(CH_NUL);
		send_text();
		text_q.push_back(CH_SPACE);
		send_text();
		// A single leftover digit, closed by a tab.
		text_q.push_back(digit_char(6'd0));
		text_q.push_back(CH_TAB);
		send_text();

		run_phase(PHASE_ITEMS, 1'b1);
		reconfigure(1'b0, 1'b0);
		run_phase(PHASE_ITEMS, 1'b0);
		reconfigure(1'b1, 1'b1);
		run_phase(PHASE_ITEMS, 1'b0);
		reconfigure(1'b0, 1'b1);
		run_phase(PHASE_ITEMS, 1'b0);
		reconfigure(1'b1, 1'b0);
		calm = 1'b1;
		run_phase(PHASE_ITEMS, 1'b0);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("base57_block_decoder_tb: clean");
		else
			$display("base57_block_decoder_tb: errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/b57_pkg.sv
rtl/b57_cmd_fifo.sv
rtl/b57_front.sv
rtl/b57_back.sv
rtl/base57_block_decoder.sv
tb/sv/b57_tb_pkg.sv
tb/sv/base57_block_decoder_checker.sv
tb/sv/base57_block_decoder_tb.sv
